// ===== src/xs1024_pkg.sv =====
// ============================================================================
// xs1024_pkg: shared types and constants of the bounded xorshift1024* core
// Request kinds, status codes, the scrambling multiplier and the redraw limit.
// ============================================================================
package xs1024_pkg;

    typedef logic [63:0] word_t;

    // request kinds
    localparam logic [2:0] REQ_BOUNDED = 3'd0;
    localparam logic [2:0] REQ_RAW     = 3'd1;
    localparam logic [2:0] REQ_WRITE   = 3'd2;
    localparam logic [2:0] REQ_COMMIT  = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    // response status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_RANGE      = 2'd1;
    localparam logic [1:0] STATUS_NOT_SEEDED = 2'd2;

    localparam word_t      STAR_MULT    = 64'd1181783497276652981;
    localparam word_t      ALL_ONES     = 64'hffff_ffff_ffff_ffff;
    localparam logic [6:0] REDRAW_LIMIT = 7'd64;

    // xorshift1024 shift amounts
    localparam int SHIFT_B_LEFT  = 31;
    localparam int SHIFT_B_RIGHT = 11;
    localparam int SHIFT_A_RIGHT = 30;

endpackage

// ===== src/xs1024_mod.sv =====
// ============================================================================
// xs1024_mod: iterative 64-bit remainder unit
// Restoring division, one dividend bit per cycle.
// ============================================================================
module xs1024_mod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  xs1024_pkg::word_t   dividend,
    input  xs1024_pkg::word_t   divisor,
    output logic                done,
    output xs1024_pkg::word_t   remainder
);
    import xs1024_pkg::*;

    word_t       dvd_reg;
    word_t       div_reg;
    word_t       rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [64:0] trial;
    logic        fits;

    assign trial = {rem_reg, dvd_reg[63]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            if (fits)
                rem_reg <= 64'(trial - {1'b0, div_reg});
            else
                rem_reg <= trial[63:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/bounded_xorshift1024star_generator_core.sv =====
// ============================================================================
// bounded_xorshift1024star_generator_core: bounded xorshift1024* generator
// Sixteen 64-bit state words in a small memory, a 4-bit cursor, a shared
// 32x32 multiplier for the scrambler and a shared iterative remainder unit.
// ============================================================================
//
//  channel  | direction | carries
//  ---------+-----------+-----------------------------------------------
//  s_*      | in        | request: kind, bound, word index, word value
//  m_*      | out       | response: value, position, status
//
//  raw draw: two memory reads, mix and write, three multiply steps,
//    check, response; the reads share the single memory read port
//    and the multiply steps share the 32x32 multiplier
//  bounded draw: a threshold pass of the remainder unit, the raw draw
//    steps per draw and per rejected draw, then a reduction pass
//  write, commit, unseeded draws: straight to response; reads: via ST_READ
//  reset clears cursor, seeded mark and handshake state; state words are
//    undefined until written; s_tready is high only in the idle state, and
//    a held response does not stop the next request from being taken
//
module bounded_xorshift1024star_generator_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,   // bound[63:0], word_index[68:64], word_value[132:69]
    input  logic [2:0]    s_tuser,   // req_type[2:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata,   // value[63:0], position[67:64]
    output logic [1:0]    m_tuser    // status[1:0]
);
    import xs1024_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_THRESH,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_MIX,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_CHECK,
        ST_REDUCE,
        ST_RESP
    } state_t;

    // request fields
    logic [2:0] in_kind;
    word_t      in_bound;
    logic [4:0] in_index;
    word_t      in_value;
    logic       accept;

    assign in_kind  = s_tuser;
    assign in_bound = s_tdata[63:0];
    assign in_index = s_tdata[68:64];
    assign in_value = s_tdata[132:69];

    // control and datapath registers
    state_t     state_reg,   state_next;
    logic [3:0] cursor_reg,  cursor_next;
    logic       seeded_reg,  seeded_next;
    logic [2:0] kind_reg,    kind_next;
    word_t      bound_reg,   bound_next;
    word_t      t_reg,       t_next;
    word_t      a_reg,       a_next;
    word_t      word_reg,    word_next;
    word_t      acc_reg,     acc_next;
    logic [6:0] k_reg,       k_next;
    word_t      res_value_reg,  res_value_next;
    logic [1:0] res_status_reg, res_status_next;
    logic       out_valid_reg,  out_valid_next;
    word_t      out_value_reg,  out_value_next;
    logic [3:0] out_pos_reg,    out_pos_next;
    logic [1:0] out_status_reg, out_status_next;

    // state word memory, one write and one registered read port
    word_t      mem [16];
    word_t      rd_data_reg;
    logic       mem_we;
    logic [3:0] mem_wa;
    word_t      mem_wd;
    logic [3:0] mem_ra;

    // shared remainder unit
    logic       mod_start;
    word_t      mod_dividend;
    word_t      mod_divisor;
    logic       mod_done;
    word_t      mod_rem;

    // shared 32x32 multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // xorshift mix of the fetched pair
    word_t      b_shift;
    word_t      mix_word;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign b_shift  = rd_data_reg ^ (rd_data_reg << SHIFT_B_LEFT);
    assign mix_word = b_shift ^ a_reg ^ (b_shift >> SHIFT_B_RIGHT) ^ (a_reg >> SHIFT_A_RIGHT);

    // low 64 bits of word * multiplier from three partial products
    always_comb
    begin
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = word_reg[31:0];
                mul_b = STAR_MULT[63:32];
            end
            ST_MUL2:
            begin
                mul_a = word_reg[63:32];
                mul_b = STAR_MULT[31:0];
            end
            default:
            begin
                mul_a = word_reg[31:0];
                mul_b = STAR_MULT[31:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    xs1024_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        seeded_next     = seeded_reg;
        kind_next       = kind_reg;
        bound_next      = bound_reg;
        t_next          = t_reg;
        a_next          = a_reg;
        word_next       = word_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        out_status_next = out_status_reg;

        mem_we       = 1'b0;
        mem_wa       = in_index[3:0];
        mem_wd       = in_value;
        mem_ra       = in_index[3:0];
        mod_start    = 1'b0;
        mod_dividend = ALL_ONES;
        mod_divisor  = bound_reg;

        case (state_reg)
            ST_IDLE:
            begin
                mod_divisor = in_bound;
                if (accept)
                begin
                    kind_next       = in_kind;
                    bound_next      = in_bound;
                    res_value_next  = '0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_RESP;
                    case (in_kind)
                        REQ_BOUNDED:
                        begin
                            if (!seeded_reg)
                                res_status_next = STATUS_NOT_SEEDED;
                            else if (in_bound != '0)
                            begin
                                // threshold (2^64-1) mod n first
                                mod_start  = 1'b1;
                                k_next     = 7'd1;
                                state_next = ST_THRESH;
                            end
                        end
                        REQ_RAW:
                        begin
                            if (!seeded_reg)
                                res_status_next = STATUS_NOT_SEEDED;
                            else
                            begin
                                k_next     = 7'd1;
                                state_next = ST_DRAW_A;
                            end
                        end
                        REQ_WRITE:
                        begin
                            if (in_index[4])
                                res_status_next = STATUS_RANGE;
                            else
                                mem_we = 1'b1;
                        end
                        REQ_COMMIT:
                        begin
                            if (in_index[4])
                            begin
                                res_status_next = STATUS_RANGE;
                                seeded_next     = 1'b0;
                            end
                            else
                            begin
                                cursor_next = in_index[3:0];
                                seeded_next = 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            // read address already presented this cycle
                            if (in_index[4])
                                res_status_next = STATUS_RANGE;
                            else
                                state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_value_next = rd_data_reg;
                state_next     = ST_RESP;
            end
            ST_THRESH:
            begin
                if (mod_done)
                begin
                    t_next     = mod_rem;
                    state_next = ST_DRAW_A;
                end
            end
            ST_DRAW_A:
            begin
                mem_ra     = cursor_reg;
                state_next = ST_DRAW_B;
            end
            ST_DRAW_B:
            begin
                // word at the cursor is back, fetch the next one
                a_next     = rd_data_reg;
                mem_ra     = 4'(cursor_reg + 4'd1);
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                mem_we      = 1'b1;
                mem_wa      = 4'(cursor_reg + 4'd1);
                mem_wd      = mix_word;
                cursor_next = 4'(cursor_reg + 4'd1);
                word_next   = mix_word;
                state_next  = ST_MUL0;
            end
            ST_MUL0:
            begin
                acc_next   = mul_p;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                acc_next   = acc_reg + {mul_p[31:0], 32'h0};
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next   = acc_reg + {mul_p[31:0], 32'h0};
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                mod_dividend = acc_reg;
                if (kind_reg != REQ_BOUNDED)
                begin
                    res_value_next = acc_reg;
                    state_next     = ST_RESP;
                end
                else if ((acc_reg < t_reg) && (k_reg < REDRAW_LIMIT))
                begin
                    // rejected, draw again
                    k_next     = 7'(k_reg + 7'd1);
                    state_next = ST_DRAW_A;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mod_done)
                begin
                    res_value_next = mod_rem;
                    state_next     = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // load the output register once it is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_pos_next    = cursor_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            seeded_reg     <= 1'b0;
            kind_reg       <= REQ_BOUNDED;
            bound_reg      <= '0;
            t_reg          <= '0;
            a_reg          <= '0;
            word_reg       <= '0;
            acc_reg        <= '0;
            k_reg          <= 7'd1;
            res_value_reg  <= '0;
            res_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_pos_reg    <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            seeded_reg     <= seeded_next;
            kind_reg       <= kind_next;
            bound_reg      <= bound_next;
            t_reg          <= t_next;
            a_reg          <= a_next;
            word_reg       <= word_next;
            acc_reg        <= acc_next;
            k_reg          <= k_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_pos_reg    <= out_pos_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_pos_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

    // each mix step advances the cursor by one
    a_cursor_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX) |=> (cursor_reg == 4'($past(cursor_reg) + 4'd1)))
        else $error("cursor did not advance after mix step");

    // the remainder unit finishes only while the sequencer waits for it
    a_mod_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> ((state_reg == ST_THRESH) || (state_reg == ST_REDUCE)))
        else $error("remainder result arrived outside a wait state");

    // redraw count stays within its limit
    a_redraw_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg <= REDRAW_LIMIT) && (k_reg != 7'd0))
        else $error("redraw count out of range");

    // an unseeded draw never carries a number
    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STATUS_NOT_SEEDED)) |-> (out_value_reg == '0))
        else $error("unseeded response carries a value");

endmodule
